// ===== hdl/half_double_converter_core_defines.svh =====
// Assertion macros shared by the converter RTL.
`ifndef HALF_DOUBLE_CONVERTER_CORE_DEFINES_SVH
`define HALF_DOUBLE_CONVERTER_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define HDC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the following cycle.
`define HDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hdc_pkg.sv =====
// Package with the conversion constants and functions of the converter.
`default_nettype none
package hdc_pkg;

  localparam int unsigned ValueW = 64;

  localparam logic [63:0] DblQnan  = 64'h7FF8_0000_0000_0000;
  localparam logic [10:0] DblExpMax = 11'h7FF;
  localparam logic [14:0] HalfQnan = 15'h7E00;
  localparam logic [14:0] HalfInf  = 15'h7C00;

  localparam logic CmdH2D = 1'b0;
  localparam logic CmdD2H = 1'b1;

  // Half to double: exact, subnormals normalised by a leading one search.
  function automatic logic [63:0] half_to_dbl(input logic [15:0] h);
    logic        sgn;
    logic [4:0]  hexp;
    logic [9:0]  hman;
    logic [3:0]  lead;
    logic [51:0] frac;
    logic [63:0] res;
    sgn  = h[15];
    hexp = h[14:10];
    hman = h[9:0];
    lead = 4'd0;
    for (int k = 0; k < 10; k++) begin
      if (hman[k]) lead = 4'(k);
    end
    frac = 52'(({42'd0, hman} << (6'd52 - {2'd0, lead})));
    if (hexp == 5'd0) begin
      if (hman == 10'd0) res = {sgn, 63'd0};
      else res = {sgn, 11'(11'd999 + {7'd0, lead}), frac};
    end else if (hexp == 5'd31) begin
      if (hman != 10'd0) res = DblQnan;
      else res = {sgn, DblExpMax, 52'd0};
    end else begin
      res = {sgn, 11'({6'd0, hexp} + 11'd1008), hman, 42'd0};
    end
    return res;
  endfunction

  // Double to half: round to nearest, ties away from zero.
  function automatic logic [15:0] dbl_to_half(input logic [63:0] d);
    logic        sgn;
    logic [10:0] dexp;
    logic [51:0] dman;
    logic [14:0] mag;
    logic [15:0] sum;
    logic [52:0] sig;
    logic [5:0]  sh;
    logic [52:0] shifted;
    logic [52:0] rbit;
    logic [10:0] units;
    sgn  = d[63];
    dexp = d[62:52];
    dman = d[51:0];
    sum  = {1'b0, dexp[4:0] + 5'd16, 10'd0} + {6'd0, dman[51:42]} + {15'd0, dman[41]};
    sig  = {1'b1, dman};
    sh   = 6'(11'd1051 - dexp);
    shifted = sig >> sh;
    rbit    = sig >> (sh - 6'd1);
    units   = 11'(shifted) + {10'd0, rbit[0]};
    if (dexp == DblExpMax) begin
      mag = (dman != 52'd0) ? HalfQnan : HalfInf;
      if (dman != 52'd0) sgn = 1'b0;
    end else if (dexp == 11'd0) begin
      mag = 15'd0;
    end else if (dexp >= 11'd1039) begin
      mag = HalfInf;
    end else if (dexp >= 11'd1009) begin
      mag = (sum[14:0] >= HalfInf) ? HalfInf : sum[14:0];
    end else if (dexp < 11'd998) begin
      mag = 15'd0;
    end else begin
      mag = {4'd0, units};
    end
    return {sgn, mag};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/half_double_converter_core.sv =====
// Top level of the half/double converter with its output register.
//
// Converts one IEEE 754 bit pattern per beat between binary16 and
// binary64. in_cmd low turns the half in in_value_in[15:0] into a
// double; in_cmd high turns the double into a half in the low 16 bits.
// Both channels use valid and stall; a beat moves when valid is high
// and stall is low at a rising edge.
// The conversion is one pass of combinational logic ahead of a single
// result register, so a new beat is taken every cycle unless the
// receiver stalls. The input is taken whenever the result register
// is empty or its beat leaves in the same cycle, so in_stall simply
// follows out_stall while a result waits.
// A synchronous active-low reset empties the result register. When the
// receiver stalls, the waiting result holds its value unchanged.
`default_nettype none
`include "half_double_converter_core_defines.svh"
module half_double_converter_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic                       in_cmd,
  input  wire logic [hdc_pkg::ValueW-1:0] in_value_in,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic [hdc_pkg::ValueW-1:0] out_value_out
);
  import hdc_pkg::*;

  logic              valid_r;
  logic [ValueW-1:0] value_r;
  logic [ValueW-1:0] value_nxt;
  logic              take;

  // The register may reload when empty or when its beat leaves now.
  assign in_stall = valid_r && out_stall;
  assign take     = in_valid && !in_stall;

  always_comb begin
    if (in_cmd == CmdD2H) value_nxt = {48'd0, dbl_to_half(in_value_in)};
    else value_nxt = half_to_dbl(in_value_in[15:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
    if (take) begin
      value_r <= value_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_value_out = value_r;

  `HDC_ASSERT_NEXT(a_take_shows, clk, rst_n, take, out_valid, "accepted beat not shown")
  `HDC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_value_out), "stalled result changed")
  `HDC_ASSERT_NEXT(a_conv, clk, rst_n, take, out_value_out == $past(value_nxt), "result differs from conversion")
  `HDC_ASSERT_IMPL(a_half_hi, clk, rst_n, take && in_cmd == CmdD2H, value_nxt[63:16] == 48'd0, "half result upper bits set")

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the half/double converter: a queue-fed driver and a result monitor.
`default_nettype none
module testbench;
  import hdc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = 1'b0;
  logic [63:0] in_value_in = 64'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_value_out;

  typedef struct packed {
    logic        cmd;
    logic [63:0] bits;
  } conv_req_t;

  conv_req_t   pending_reqs[$];
  logic [63:0] expected_vals[$];
  int          fail_count = 0;
  int          results_seen = 0;
  int          idle_cycles = 0;
  int          cycle_count = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          stim_done = 1'b0;

  half_double_converter_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_value_in(in_value_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_value_out(out_value_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Exact widening of a half into a double; every half NaN becomes the quiet NaN.
  function automatic logic [63:0] widen_half(input logic [15:0] h);
    logic [63:0] top;
    logic [63:0] man;
    int          lead;
    top  = {h[15], 63'd0};
    man  = {54'd0, h[9:0]};
    lead = 0;
    if (h[14:10] == 5'd31) begin
      return (h[9:0] != 10'd0) ? 64'h7FF8_0000_0000_0000 : (top | 64'h7FF0_0000_0000_0000);
    end
    if (h[14:10] != 5'd0) begin
      return top | ({53'd0, 11'(h[14:10] + 11'd1008)} << 52) | (man << 42);
    end
    if (h[9:0] == 10'd0) return top;
    for (int k = 0; k < 10; k++) if (h[k]) lead = k;
    return top | (64'(lead + 999) << 52) | ((man << (52 - lead)) & 64'h000F_FFFF_FFFF_FFFF);
  endfunction

  // Narrowing with round to nearest, ties away from zero.
  function automatic logic [63:0] narrow_double(input logic [63:0] d);
    logic [15:0] top;
    logic [63:0] sig;
    logic [63:0] mag;
    int          hx;
    int          sh;
    top = {d[63], 15'd0};
    if (d[62:52] == 11'h7FF) begin
      return (d[51:0] != 52'd0) ? 64'h7E00 : {48'd0, top | 16'h7C00};
    end
    if (d[62:52] == 11'd0) return {48'd0, top};
    hx = int'(d[62:52]) - 1008;
    if (hx >= 31) return {48'd0, top | 16'h7C00};
    if (hx >= 1) begin
      mag = (64'(hx) << 10) + 64'(d[51:42]) + 64'(d[41]);
      if (mag >= 64'h7C00) return {48'd0, top | 16'h7C00};
      return {48'd0, top} | mag;
    end
    if (hx < -10) return {48'd0, top};
    sig = {11'd0, 1'b1, d[51:0]};
    sh  = 43 - hx;
    mag = (sig >> sh) + ((sig >> (sh - 1)) & 64'd1);
    return {48'd0, top} | mag;
  endfunction

  function automatic logic [63:0] convert(input conv_req_t r);
    return r.cmd ? narrow_double(r.bits) : widen_half(r.bits[15:0]);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Doubles spread around the half range, so that every rounding path is reached.
  function automatic logic [63:0] near_half_double();
    logic [63:0] d;
    d = rand64();
    d[62:52] = 11'($urandom_range(990, 1045));
    if ($urandom_range(0, 3) == 0) d[40:0] = ($urandom_range(0, 1) != 0) ? '0 : '1;
    return d;
  endfunction

  // The driver presents the queue head and pops it only once the beat is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) void'(pending_reqs.pop_front());
      if (((in_valid && !in_stall) || !in_valid) && pending_reqs.size() != 0 &&
          (cycle_count < 300 || cycle_count > 600 || $urandom_range(0, 99) >= 38)) begin
        in_valid    <= 1'b1;
        in_cmd      <= pending_reqs[0].cmd;
        in_value_in <= pending_reqs[0].bits;
      end else if (!in_valid || !in_stall) begin
        in_valid <= 1'b0;
      end
    end
  end

  // The expectation is taken from the accepted beat, at the same edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) expected_vals.push_back(convert({in_cmd, in_value_in}));
  end

  // The receiver stalls at random and once holds off long enough to back the block up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && cycle_count == 1000) begin
      hold_done <= 1'b1;
      hold_left <= 60;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (cycle_count >= 300 && cycle_count <= 600) ? 1'b0 : ($urandom_range(0, 99) < 38);
    end
  end

  // The monitor compares every result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_vals.size() == 0) begin
        $error("value_out: result beat with no expectation, actual %h", out_value_out);
        fail_count <= fail_count + 1;
      end else begin
        if (out_value_out !== expected_vals[0]) begin
          $error("value_out: expected %h actual %h", expected_vals[0], out_value_out);
          fail_count <= fail_count + 1;
        end
        void'(expected_vals.pop_front());
      end
    end
  end

  // The watchdog counts cycles without any accepted beat.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && idle_cycles > 2000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [63:0] d;
    // Directed halves: zeros, smallest and largest subnormals, normals, infinities, NaNs,
    // and junk in the upper bits that must be ignored.
    logic [15:0] halves[12] = '{16'h0000, 16'h8000, 16'h0001, 16'h03FF, 16'h8200, 16'h0400,
                                16'h7BFF, 16'h3C00, 16'h7C00, 16'hFC00, 16'h7C01, 16'hFFFF};
    // Directed doubles: signed zeros, a subnormal, 2^-25 exactly and just below, a subnormal
    // that carries into the smallest normal, overflow, rounding into infinity, inf and NaNs.
    logic [63:0] doubles[13] = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                                 64'h0000_0000_0000_0001, 64'h3E60_0000_0000_0000,
                                 64'h3E5F_FFFF_FFFF_FFFF, 64'h3F0F_FFFF_FFFF_FFFF,
                                 64'h3FF0_0000_0000_0000, 64'h40EF_FE00_0000_0000,
                                 64'hC0F0_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                                 64'hFFF0_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF,
                                 64'h3F10_0200_0000_0000};
    foreach (halves[i]) pending_reqs.push_back({CmdH2D, (i == 11) ? ~64'hFFFF | 64'(halves[i])
                                                                  : 64'(halves[i])});
    foreach (doubles[i]) pending_reqs.push_back({CmdD2H, doubles[i]});
    for (int n = 0; n < 1000; n++) begin
      case ($urandom_range(0, 3))
        0: pending_reqs.push_back({CmdH2D, rand64()});
        1: pending_reqs.push_back({CmdD2H, rand64()});
        default: begin
          d = near_half_double();
          pending_reqs.push_back({CmdD2H, d});
        end
      endcase
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // Wait until the queue is drained, no beat is offered and no result is left waiting.
    while (pending_reqs.size() != 0 || in_valid || expected_vals.size() != 0 || out_valid)
      @(posedge clk);
    repeat (5) @(posedge clk);
    $display("Converted %0d beats in both directions, with random stalls and one long hold-off.",
             results_seen);
    if (fail_count == 0 && expected_vals.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/hdc_pkg.sv
hdl/half_double_converter_core.sv
bench/testbench.sv
